// ===== hw/rtl/ntcbt_pkg.sv =====
// shared constants, item types and helper functions of the ntc beta temperature unit
package ntcbt_pkg;

   // field and register widths
   localparam int RAW_BITS   = 16;
   localparam int FRAC_BITS  = 24;
   localparam int FULL_W     = 17;
   localparam int OHM_W      = 20;
   localparam int TEMP_W     = 12;
   localparam int BETA_W     = 14;
   localparam int OUT_W      = 16;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIES     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOM_TEMP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA       = 3'd4;

   localparam logic [FULL_W-1:0]        FULL_RESET     = 17'd4096;
   localparam logic [OHM_W-1:0]         SERIES_RESET   = 20'd10000;
   localparam logic [OHM_W-1:0]         NOMINAL_RESET  = 20'd10000;
   localparam logic signed [TEMP_W-1:0] NOM_TEMP_RESET = 12'sd250;
   localparam logic [BETA_W-1:0]        BETA_RESET     = 14'd3950;

   // datapath widths
   localparam int PROD_W   = OHM_W + FULL_W;
   localparam int E_W      = $clog2(PROD_W);
   localparam int MANT_W   = FRAC_BITS + 1;
   localparam int LOG_W    = E_W + FRAC_BITS;
   localparam int LN2_W    = 32;
   localparam logic [LN2_W-1:0] LN2_Q32 = 32'hB17217F8;
   localparam int K_W      = 14;
   localparam int K_OFFSET = 5463;
   localparam int KLN_W    = (K_W + 1) + (LOG_W + 1);
   localparam int D_W      = KLN_W + 2;
   localparam int DM_W     = D_W - 1;
   localparam int KB_W     = K_W + BETA_W + 4;
   localparam int Q_W      = KB_W + FRAC_BITS;
   localparam int QUOT_W   = 21;
   localparam int DSH_W    = DM_W + QUOT_W - 1;
   localparam int FIN_W    = QUOT_W + 3;

   typedef struct packed {
      logic                 inv;
      logic [E_W-1:0]       exp_num;
      logic [E_W-1:0]       exp_den;
      logic [MANT_W-1:0]    mant_num;
      logic [MANT_W-1:0]    mant_den;
      logic [FRAC_BITS-1:0] frac_num;
      logic [FRAC_BITS-1:0] frac_den;
   } log_item_type;

   typedef struct packed {
      logic              inv;
      logic              dzero;
      logic              dneg;
      logic              over;
      logic [DM_W-1:0]   dmag;
      logic [DSH_W-1:0]  dshift;
      logic [Q_W-1:0]    rem;
      logic [QUOT_W-1:0] quot;
   } div_item_type;

   // index of the leading one, zero for a zero word
   function automatic logic [E_W-1:0] msb_index(input logic [PROD_W-1:0] v);
      logic [E_W-1:0] e;
      e = '0;
      for (int i = 0; i < PROD_W; i++) begin
         if (v[i]) begin
            e = E_W'(i);
         end
      end
      return e;
   endfunction

   // mantissa in Q1.FRAC_BITS, truncated when shifted down
   function automatic logic [MANT_W-1:0] normalise(input logic [PROD_W-1:0] v,
                                                   input logic [E_W-1:0] e);
      logic [PROD_W-1:0] shr;
      logic [MANT_W-1:0] res;
      if (e >= E_W'(FRAC_BITS)) begin
         shr = v >> (e - E_W'(FRAC_BITS));
         res = shr[MANT_W-1:0];
      end else begin
         res = v[MANT_W-1:0] << (E_W'(FRAC_BITS) - e);
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/ntcbt_log_cell.sv =====
// one squaring step of the two fractional log2 evaluations
module ntcbt_log_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  ntcbt_pkg::log_item_type in_item,
   output logic                    in_ready,
   output logic                    out_valid,
   output ntcbt_pkg::log_item_type out_item,
   input  logic                    out_ready
);

   logic                    valid_ff;
   ntcbt_pkg::log_item_type item_ff;
   ntcbt_pkg::log_item_type item_in;
   logic [2*ntcbt_pkg::MANT_W-1:0] sq_num;
   logic [2*ntcbt_pkg::MANT_W-1:0] sq_den;
   logic [ntcbt_pkg::MANT_W:0]     t_num;
   logic [ntcbt_pkg::MANT_W:0]     t_den;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      sq_num = (2*ntcbt_pkg::MANT_W)'(in_item.mant_num) *
               (2*ntcbt_pkg::MANT_W)'(in_item.mant_num);
      sq_den = (2*ntcbt_pkg::MANT_W)'(in_item.mant_den) *
               (2*ntcbt_pkg::MANT_W)'(in_item.mant_den);
      t_num  = sq_num[2*ntcbt_pkg::MANT_W-1:ntcbt_pkg::FRAC_BITS];
      t_den  = sq_den[2*ntcbt_pkg::MANT_W-1:ntcbt_pkg::FRAC_BITS];
      item_in = in_item;
      // reaching 2.0 gives a one bit and halves the mantissa
      item_in.mant_num = t_num[ntcbt_pkg::MANT_W] ? t_num[ntcbt_pkg::MANT_W:1]
                                                  : t_num[ntcbt_pkg::MANT_W-1:0];
      item_in.mant_den = t_den[ntcbt_pkg::MANT_W] ? t_den[ntcbt_pkg::MANT_W:1]
                                                  : t_den[ntcbt_pkg::MANT_W-1:0];
      item_in.frac_num = {in_item.frac_num[ntcbt_pkg::FRAC_BITS-2:0],
                          t_num[ntcbt_pkg::MANT_W]};
      item_in.frac_den = {in_item.frac_den[ntcbt_pkg::FRAC_BITS-2:0],
                          t_den[ntcbt_pkg::MANT_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== hw/rtl/ntcbt_div_cell.sv =====
// one restoring step of the temperature quotient
module ntcbt_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  ntcbt_pkg::div_item_type in_item,
   output logic                    in_ready,
   output logic                    out_valid,
   output ntcbt_pkg::div_item_type out_item,
   input  logic                    out_ready
);

   logic                    valid_ff;
   ntcbt_pkg::div_item_type item_ff;
   ntcbt_pkg::div_item_type item_in;
   logic                    fits;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      fits    = ntcbt_pkg::DSH_W'(in_item.rem) >= in_item.dshift;
      item_in = in_item;
      if (fits) begin
         item_in.rem = in_item.rem - in_item.dshift[ntcbt_pkg::Q_W-1:0];
      end
      item_in.quot   = {in_item.quot[ntcbt_pkg::QUOT_W-2:0], fits};
      item_in.dshift = in_item.dshift >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== hw/rtl/ntc_beta_temperature_unit.sv =====
// top level of the ntc beta temperature unit: front end, log and divide chains, output
// path: an accepted word passes 4 front stages, 24 log cells, 5 middle stages,
//   21 divide cells, 1 finishing stage and the output register before rsp_valid rises
// throughput: one word per cycle while rsp_stall is low; every stage and cell has its
//   own valid and moves on once the next is free, so bubbles close up behind a stall
// reset: synchronous, clears all valid flags and loads the register defaults
//   (4096 counts, 10000 ohms, 10000 ohms, 25.0 degC, beta 3950)
module ntc_beta_temperature_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ntcbt_pkg::RAW_BITS-1:0]        req_raw_sample,
   // temperature output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ntcbt_pkg::OUT_W-1:0]    rsp_temp_deci,
   output logic                                  rsp_status,
   // register writes
   input  logic                                  csr_write,
   input  logic [ntcbt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ntcbt_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int NLOG = ntcbt_pkg::FRAC_BITS;
   localparam int NDIV = ntcbt_pkg::QUOT_W;

   // ---------------------------------------------------------------- registers
   logic [ntcbt_pkg::FULL_W-1:0]        full_ff;
   logic [ntcbt_pkg::OHM_W-1:0]         series_ff;
   logic [ntcbt_pkg::OHM_W-1:0]         nominal_ff;
   logic signed [ntcbt_pkg::TEMP_W-1:0] nom_temp_ff;
   logic [ntcbt_pkg::BETA_W-1:0]        beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff     <= ntcbt_pkg::FULL_RESET;
         series_ff   <= ntcbt_pkg::SERIES_RESET;
         nominal_ff  <= ntcbt_pkg::NOMINAL_RESET;
         nom_temp_ff <= ntcbt_pkg::NOM_TEMP_RESET;
         beta_ff     <= ntcbt_pkg::BETA_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ntcbt_pkg::CSR_FULL_SCALE: full_ff <= csr_data[ntcbt_pkg::FULL_W-1:0];
            ntcbt_pkg::CSR_SERIES:     series_ff <= csr_data[ntcbt_pkg::OHM_W-1:0];
            ntcbt_pkg::CSR_NOMINAL:    nominal_ff <= csr_data[ntcbt_pkg::OHM_W-1:0];
            ntcbt_pkg::CSR_NOM_TEMP:
               nom_temp_ff <= $signed(csr_data[ntcbt_pkg::TEMP_W-1:0]);
            ntcbt_pkg::CSR_BETA:       beta_ff <= csr_data[ntcbt_pkg::BETA_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake chain
   logic out_ready;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff;
   logic s10_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;
   logic s5_ready, s6_ready, s7_ready, s8_ready, s9_ready, s10_ready;

   logic [NLOG:0]           log_valid;
   logic [NLOG:0]           log_ready;
   ntcbt_pkg::log_item_type log_item [0:NLOG];
   logic [NDIV:0]           div_valid;
   logic [NDIV:0]           div_ready;
   ntcbt_pkg::div_item_type div_item [0:NDIV];

   // a stage takes a new word when empty or when its own word moves on
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s10_ready = !s10_valid_ff || out_ready;
   assign div_ready[NDIV] = s10_ready;
   assign s9_ready  = !s9_valid_ff || div_ready[0];
   assign s8_ready  = !s8_valid_ff || s9_ready;
   assign s7_ready  = !s7_valid_ff || s8_ready;
   assign s6_ready  = !s6_valid_ff || s7_ready;
   assign s5_ready  = !s5_valid_ff || s6_ready;
   assign log_ready[NLOG] = s5_ready;
   assign s4_ready  = !s4_valid_ff || log_ready[0];
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_valid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (s4_ready)  s4_valid_ff  <= s3_valid_ff;
         if (s5_ready)  s5_valid_ff  <= log_valid[NLOG];
         if (s6_ready)  s6_valid_ff  <= s5_valid_ff;
         if (s7_ready)  s7_valid_ff  <= s6_valid_ff;
         if (s8_ready)  s8_valid_ff  <= s7_valid_ff;
         if (s9_ready)  s9_valid_ff  <= s8_valid_ff;
         if (s10_ready) s10_valid_ff <= div_valid[NDIV];
         if (out_ready) rsp_valid_ff <= s10_valid_ff;
      end
   end

   // ---------------------------------------------------------------- s1: capture, validity
   logic [ntcbt_pkg::RAW_BITS-1:0] raw1_ff;
   logic                           inv1_ff;
   logic                           inv1_in;

   // zero or over-range count, or a zero resistor or beta, makes the word invalid
   assign inv1_in = (req_raw_sample == '0) ||
                    (ntcbt_pkg::FULL_W'(req_raw_sample) >= full_ff) ||
                    (series_ff == '0) || (nominal_ff == '0) || (beta_ff == '0);

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         raw1_ff <= req_raw_sample;
         inv1_ff <= inv1_in;
      end
   end

   // ---------------------------------------------------------------- s2: ratio products
   logic [ntcbt_pkg::PROD_W-1:0] num2_ff, den2_ff;
   logic                         inv2_ff;
   logic [ntcbt_pkg::FULL_W-1:0] rest_counts;

   assign rest_counts = full_ff - ntcbt_pkg::FULL_W'(raw1_ff);

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         num2_ff <= ntcbt_pkg::PROD_W'(series_ff) * ntcbt_pkg::PROD_W'(raw1_ff);
         den2_ff <= ntcbt_pkg::PROD_W'(rest_counts) * ntcbt_pkg::PROD_W'(nominal_ff);
         inv2_ff <= inv1_ff;
      end
   end

   // ---------------------------------------------------------------- s3: leading one
   logic [ntcbt_pkg::PROD_W-1:0] num3_ff, den3_ff;
   logic [ntcbt_pkg::E_W-1:0]    exp_num3_ff, exp_den3_ff;
   logic                         inv3_ff;

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         num3_ff     <= num2_ff;
         den3_ff     <= den2_ff;
         exp_num3_ff <= ntcbt_pkg::msb_index(num2_ff);
         exp_den3_ff <= ntcbt_pkg::msb_index(den2_ff);
         inv3_ff     <= inv2_ff;
      end
   end

   // ---------------------------------------------------------------- s4: normalise
   ntcbt_pkg::log_item_type s4_item_ff;
   ntcbt_pkg::log_item_type s4_item_in;

   always_comb begin
      s4_item_in.inv      = inv3_ff;
      s4_item_in.exp_num  = exp_num3_ff;
      s4_item_in.exp_den  = exp_den3_ff;
      s4_item_in.mant_num = ntcbt_pkg::normalise(num3_ff, exp_num3_ff);
      s4_item_in.mant_den = ntcbt_pkg::normalise(den3_ff, exp_den3_ff);
      s4_item_in.frac_num = '0;
      s4_item_in.frac_den = '0;
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_item_ff <= s4_item_in;
      end
   end

   // ---------------------------------------------------------------- log2 cells
   // each cell squares both mantissas once and yields one fraction bit of each log
   assign log_valid[0] = s4_valid_ff;
   assign log_item[0]  = s4_item_ff;

   for (genvar i = 0; i < NLOG; i++) begin : g_log
      ntcbt_log_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (log_valid[i]),
         .in_item   (log_item[i]),
         .in_ready  (log_ready[i]),
         .out_valid (log_valid[i+1]),
         .out_item  (log_item[i+1]),
         .out_ready (log_ready[i+1])
      );
   end

   // ---------------------------------------------------------------- s5: log difference
   logic [ntcbt_pkg::LOG_W-1:0] lg_num, lg_den;
   logic [ntcbt_pkg::LOG_W:0]   diff, diff_neg;
   logic [ntcbt_pkg::LOG_W-1:0] mag5_ff;
   logic                        neg5_ff, inv5_ff;

   always_comb begin
      lg_num   = {log_item[NLOG].exp_num, log_item[NLOG].frac_num};
      lg_den   = {log_item[NLOG].exp_den, log_item[NLOG].frac_den};
      diff     = {1'b0, lg_num} - {1'b0, lg_den};
      diff_neg = -diff;
   end

   always_ff @(posedge clock) begin
      if (s5_ready && log_valid[NLOG]) begin
         neg5_ff <= diff[ntcbt_pkg::LOG_W];
         mag5_ff <= diff[ntcbt_pkg::LOG_W] ? diff_neg[ntcbt_pkg::LOG_W-1:0]
                                           : diff[ntcbt_pkg::LOG_W-1:0];
         inv5_ff <= log_item[NLOG].inv;
      end
   end

   // ---------------------------------------------------------------- s6: times ln 2
   localparam int LNP_W = ntcbt_pkg::LOG_W + ntcbt_pkg::LN2_W;
   logic [LNP_W-1:0]                   ln_prod;
   logic [ntcbt_pkg::LOG_W:0]          ln_mag_ext;
   logic signed [ntcbt_pkg::LOG_W:0]   ln6_ff;
   logic                               inv6_ff;

   always_comb begin
      ln_prod    = LNP_W'(mag5_ff) * LNP_W'(ntcbt_pkg::LN2_Q32);
      ln_mag_ext = {1'b0, ln_prod[LNP_W-1:ntcbt_pkg::LN2_W]};
   end

   always_ff @(posedge clock) begin
      if (s6_ready && s5_valid_ff) begin
         ln6_ff  <= neg5_ff ? $signed(-ln_mag_ext) : $signed(ln_mag_ext);
         inv6_ff <= inv5_ff;
      end
   end

   // ---------------------------------------------------------------- s7: K products
   // K = 2*T0deci + 5463 is twenty times T0 in kelvin, always positive
   logic signed [ntcbt_pkg::K_W:0]      k_full;
   logic [ntcbt_pkg::K_W-1:0]           k_val;
   logic [ntcbt_pkg::KB_W-1:0]          kb, kb10;
   logic signed [ntcbt_pkg::KLN_W-1:0]  kln7_ff;
   logic [ntcbt_pkg::Q_W-1:0]           q7_ff;
   logic                                inv7_ff;

   always_comb begin
      k_full = ($signed({{(ntcbt_pkg::K_W+1-ntcbt_pkg::TEMP_W){nom_temp_ff[ntcbt_pkg::TEMP_W-1]}},
                         nom_temp_ff}) <<< 1) + (ntcbt_pkg::K_W+1)'(ntcbt_pkg::K_OFFSET);
      k_val  = k_full[ntcbt_pkg::K_W-1:0];
      kb     = ntcbt_pkg::KB_W'(k_val) * ntcbt_pkg::KB_W'(beta_ff);
      kb10   = (kb << 3) + (kb << 1);
   end

   always_ff @(posedge clock) begin
      if (s7_ready && s6_valid_ff) begin
         kln7_ff <= $signed({1'b0, k_val}) * ln6_ff;
         q7_ff   <= {kb10, {ntcbt_pkg::FRAC_BITS{1'b0}}};
         inv7_ff <= inv6_ff;
      end
   end

   // ---------------------------------------------------------------- s8: divisor
   localparam int B20_W = ntcbt_pkg::BETA_W + 5;
   logic [B20_W-1:0]                  beta20;
   logic signed [ntcbt_pkg::D_W-1:0]  d_sum, d_neg;
   logic [ntcbt_pkg::DM_W-1:0]        dmag8_ff;
   logic                              dneg8_ff, dzero8_ff, inv8_ff;
   logic [ntcbt_pkg::Q_W-1:0]         q8_ff;

   always_comb begin
      beta20 = (B20_W'(beta_ff) << 4) + (B20_W'(beta_ff) << 2);
      d_sum  = $signed(ntcbt_pkg::D_W'(beta20) << ntcbt_pkg::FRAC_BITS) +
               $signed({{(ntcbt_pkg::D_W-ntcbt_pkg::KLN_W){kln7_ff[ntcbt_pkg::KLN_W-1]}},
                        kln7_ff});
      d_neg  = -d_sum;
   end

   always_ff @(posedge clock) begin
      if (s8_ready && s7_valid_ff) begin
         dzero8_ff <= (d_sum == '0);
         dneg8_ff  <= d_sum[ntcbt_pkg::D_W-1];
         dmag8_ff  <= d_sum[ntcbt_pkg::D_W-1] ? d_neg[ntcbt_pkg::DM_W-1:0]
                                              : d_sum[ntcbt_pkg::DM_W-1:0];
         q8_ff     <= q7_ff;
         inv8_ff   <= inv7_ff;
      end
   end

   // ---------------------------------------------------------------- s9: range check
   // a quotient of 2^21 or more can only end capped, so it is flagged as over here
   ntcbt_pkg::div_item_type s9_item_ff;
   ntcbt_pkg::div_item_type s9_item_in;

   always_comb begin
      s9_item_in.inv    = inv8_ff;
      s9_item_in.dzero  = dzero8_ff;
      s9_item_in.dneg   = dneg8_ff;
      s9_item_in.over   = (ntcbt_pkg::DSH_W+1)'(q8_ff) >= {dmag8_ff, {NDIV{1'b0}}};
      s9_item_in.dmag   = dmag8_ff;
      s9_item_in.dshift = {dmag8_ff, {(NDIV-1){1'b0}}};
      s9_item_in.rem    = q8_ff;
      s9_item_in.quot   = '0;
   end

   always_ff @(posedge clock) begin
      if (s9_ready && s8_valid_ff) begin
         s9_item_ff <= s9_item_in;
      end
   end

   // ---------------------------------------------------------------- divide cells
   assign div_valid[0] = s9_valid_ff;
   assign div_item[0]  = s9_item_ff;

   for (genvar j = 0; j < NDIV; j++) begin : g_div
      ntcbt_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[j]),
         .in_item   (div_item[j]),
         .in_ready  (div_ready[j]),
         .out_valid (div_valid[j+1]),
         .out_item  (div_item[j+1]),
         .out_ready (div_ready[j+1])
      );
   end

   // ---------------------------------------------------------------- s10: rounding pair
   // w is twice the quotient plus a half bit, wc its upper neighbour unless exact
   ntcbt_pkg::div_item_type              dq;
   logic                                 capped, exact, half;
   logic [NDIV-1:0]                      a_val;
   logic [ntcbt_pkg::Q_W-1:0]            r_val;
   logic [ntcbt_pkg::Q_W:0]              r_twice, dm_ext;
   logic [NDIV:0]                        w_val;
   logic signed [ntcbt_pkg::FIN_W-1:0]   w_s, wc_s, f2_in, c2_in;
   logic signed [ntcbt_pkg::FIN_W-1:0]   f2_ff, c2_ff;
   logic                                 inv10_ff, dzero10_ff;

   always_comb begin
      dq      = div_item[NDIV];
      capped  = dq.over || dq.quot[NDIV-1];
      a_val   = capped ? (NDIV'(1) << (NDIV-1)) : dq.quot;
      r_val   = capped ? '0 : dq.rem;
      r_twice = {r_val, 1'b0};
      dm_ext  = (ntcbt_pkg::Q_W+1)'(dq.dmag);
      exact   = (r_val == '0) || (r_twice == dm_ext);
      half    = r_twice >= dm_ext;
      w_val   = {a_val, half};
      w_s     = $signed(ntcbt_pkg::FIN_W'(w_val));
      wc_s    = w_s + $signed(ntcbt_pkg::FIN_W'(!exact));
      f2_in   = (dq.dneg ? -wc_s : w_s) - ntcbt_pkg::FIN_W'(ntcbt_pkg::K_OFFSET);
      c2_in   = (dq.dneg ? -w_s : wc_s) - ntcbt_pkg::FIN_W'(ntcbt_pkg::K_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (s10_ready && div_valid[NDIV]) begin
         f2_ff      <= f2_in;
         c2_ff      <= c2_in;
         inv10_ff   <= dq.inv;
         dzero10_ff <= dq.dzero;
      end
   end

   // ---------------------------------------------------------------- output register
   logic signed [ntcbt_pkg::FIN_W-1:0] c2_neg, halved;
   logic signed [ntcbt_pkg::OUT_W-1:0] temp_in, temp_ff;
   logic                               status_ff;

   always_comb begin
      c2_neg = -c2_ff;
      // halve toward zero
      if (f2_ff >= 0) begin
         halved = f2_ff >>> 1;
      end else if (c2_ff >= 0) begin
         halved = c2_ff >>> 1;
      end else begin
         halved = -(c2_neg >>> 1);
      end
      if (inv10_ff) begin
         temp_in = '0;
      end else if (dzero10_ff) begin
         temp_in = 16'sh7FFF;
      end else if (halved > $signed(ntcbt_pkg::FIN_W'(16'sh7FFF))) begin
         temp_in = 16'sh7FFF;
      end else if (halved < -$signed(ntcbt_pkg::FIN_W'(17'h08000))) begin
         temp_in = 16'sh8000;
      end else begin
         temp_in = halved[ntcbt_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s10_valid_ff) begin
         temp_ff   <= temp_in;
         status_ff <= inv10_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_temp_deci = temp_ff;
   assign rsp_status    = status_ff;

endmodule

// ===== tb/ntcbt_checker.sv =====
// checker of the ntc beta temperature unit: register copy, temperature predictor, comparison
`timescale 1ns / 100ps

module ntcbt_checker
   import ntcbt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [RAW_BITS-1:0]   req_raw_sample,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic signed [OUT_W-1:0] rsp_temp_deci,
   input  logic                  rsp_status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   typedef struct {
      logic signed [OUT_W-1:0] temp_deci;
      logic                    status;
   } temp_word_type;

   localparam longint unsigned LN2_MULT = 64'hB17217F8;
   localparam longint QUOT_LIMIT        = 64'd1 << 20;

   logic [FULL_W-1:0]        full_scale;
   logic [OHM_W-1:0]         series_ohms;
   logic [OHM_W-1:0]         nominal_ohms;
   logic signed [TEMP_W-1:0] nominal_temp;
   logic [BETA_W-1:0]        beta;

   temp_word_type expected_temps[$];

   assign pending = expected_temps.size();

   // log2 in unsigned Q.FRAC_BITS by repeated squaring of the mantissa
   function automatic longint unsigned log2_q(input longint unsigned v);
      int unsigned     e;
      longint unsigned mant;
      longint unsigned frac;
      bit [127:0]      sq;
      e    = 0;
      frac = 0;
      while (e < 63 && (v >> (e + 1)) != 0) e++;
      if (e >= FRAC_BITS) mant = v >> (e - FRAC_BITS);
      else mant = v << (FRAC_BITS - e);
      for (int i = FRAC_BITS; i > 0; i--) begin
         sq   = 128'(mant) * 128'(mant);
         mant = 64'(sq >> FRAC_BITS);
         if (mant >= (64'd2 << FRAC_BITS)) begin
            mant = mant >> 1;
            frac = frac | (64'd1 << (i - 1));
         end
      end
      return (longint'(e) << FRAC_BITS) | frac;
   endfunction

   function automatic temp_word_type predict_temp(input logic [RAW_BITS-1:0] raw);
      temp_word_type   w;
      longint unsigned num, den, mag, lnmag, q, dm, a, r, wq, wc;
      longint          diff, ln_q, k, d, f2, c2, res;
      bit [127:0]      prod;
      bit              exact;
      w.temp_deci = '0;
      w.status    = 1'b1;
      if (raw == 0 || raw >= full_scale || series_ohms == 0 || nominal_ohms == 0 || beta == 0)
         return w;
      w.status = 1'b0;
      num  = longint'(series_ohms) * longint'(raw);
      den  = (longint'(full_scale) - longint'(raw)) * longint'(nominal_ohms);
      diff = longint'(log2_q(num)) - longint'(log2_q(den));
      mag  = diff < 0 ? -diff : diff;
      prod = 128'(mag) * 128'(LN2_MULT);
      lnmag = 64'(prod >> 32);
      ln_q = diff < 0 ? -longint'(lnmag) : longint'(lnmag);
      k = 2 * longint'(nominal_temp) + K_OFFSET;
      d = ((64'd20 * longint'(beta)) << FRAC_BITS) + k * ln_q;
      if (d == 0) begin
         res = 32767;
      end else begin
         q  = (64'd10 * k * longint'(beta)) << FRAC_BITS;
         dm = d > 0 ? d : -d;
         a  = q / dm;
         r  = q % dm;
         if (a >= QUOT_LIMIT) begin
            a = QUOT_LIMIT;
            r = 0;
         end
         exact = (r == 0) || (2 * r == dm);
         wq = 2 * a + ((2 * r >= dm) ? 1 : 0);
         wc = wq + (exact ? 0 : 1);
         if (d > 0) begin
            f2 = wq;
            c2 = wc;
         end else begin
            f2 = -longint'(wc);
            c2 = -longint'(wq);
         end
         f2 = f2 - K_OFFSET;
         c2 = c2 - K_OFFSET;
         res = (f2 >= 0) ? f2 / 2 : c2 / 2;
         if (res > 32767) res = 32767;
         if (res < -32768) res = -32768;
      end
      w.temp_deci = OUT_W'(res);
      return w;
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      temp_word_type want;
      if (reset) begin
         full_scale   <= FULL_RESET;
         series_ohms  <= SERIES_RESET;
         nominal_ohms <= NOMINAL_RESET;
         nominal_temp <= NOM_TEMP_RESET;
         beta         <= BETA_RESET;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FULL_SCALE: full_scale   <= csr_data[FULL_W-1:0];
               CSR_SERIES:     series_ohms  <= csr_data[OHM_W-1:0];
               CSR_NOMINAL:    nominal_ohms <= csr_data[OHM_W-1:0];
               CSR_NOM_TEMP:   nominal_temp <= csr_data[TEMP_W-1:0];
               CSR_BETA:       beta         <= csr_data[BETA_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_temps.push_back(predict_temp(req_raw_sample));
         if (rsp_valid && !rsp_stall) begin
            if (expected_temps.size() == 0) begin
               $error("unexpected word: temp_deci %0d status %0d", rsp_temp_deci, rsp_status);
               fail_count++;
            end else begin
               want = expected_temps.pop_front();
               if (rsp_temp_deci !== want.temp_deci) begin
                  $error("temp_deci expected %0d actual %0d", want.temp_deci, rsp_temp_deci);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ===== tb/tb_ntc_beta_temperature_unit.sv =====
// testbench top of the ntc beta temperature unit: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_ntc_beta_temperature_unit;
   import ntcbt_pkg::*;

   // a register index the block does not have, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int DRAIN_CYCLES   = 70;  // a little over the pipeline latency
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_WORDS    = 210;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [RAW_BITS-1:0]     req_raw_sample = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_temp_deci;
   logic                    rsp_status;
   logic                    csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;
   int                      fail_count;
   int                      pending;

   // our copy of full scale, only to aim the raw counts
   int unsigned             full_now = FULL_RESET;

   // raised by the sample side once a long run of words is about to start
   logic                    hold_go = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ntc_beta_temperature_unit DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_raw_sample,
      .rsp_valid, .rsp_stall, .rsp_temp_deci, .rsp_status,
      .csr_write, .csr_index, .csr_data
   );

   ntcbt_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_raw_sample,
      .rsp_valid, .rsp_stall, .rsp_temp_deci, .rsp_status,
      .csr_write, .csr_index, .csr_data,
      .fail_count, .pending
   );

   // mostly no gap, sometimes a short one, now and then a long one
   function automatic int pick_gap();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   // offer one word and hold it until the block takes it
   task automatic send_sample(input logic [RAW_BITS-1:0] raw, input int gap);
      req_valid      <= 1'b1;
      req_raw_sample <= raw;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // registers only change with the pipe empty
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_FULL_SCALE) full_now = value & 32'h1FFFF;
   endtask

   task automatic write_all(input int unsigned full, input int unsigned series,
                            input int unsigned nominal, input int ntemp,
                            input int unsigned b);
      write_reg(CSR_FULL_SCALE, full);
      write_reg(CSR_SERIES, series);
      write_reg(CSR_NOMINAL, nominal);
      write_reg(CSR_NOM_TEMP, ntemp & 32'hFFF);
      write_reg(CSR_BETA, b);
   endtask

   // counts around the interesting corners of the current full scale
   function automatic logic [RAW_BITS-1:0] pick_raw();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 70 && full_now >= 2) return RAW_BITS'($urandom_range(1, full_now - 1));
      if (p < 80 && full_now >= 2) return RAW_BITS'($urandom_range(1, 3));
      if (p < 90 && full_now >= 4) return RAW_BITS'(full_now - $urandom_range(1, 3));
      return RAW_BITS'($urandom_range(16'hFFFF));
   endfunction

   // result side: one long hold while words keep coming, then random stall runs
   initial begin
      int n;
      wait (hold_go);
      @(posedge clock);
      rsp_stall <= 1'b1;
      n = 0;
      while (n < 250) begin
         @(posedge clock);
         n++;
      end
      rsp_stall <= 1'b0;
      forever begin
         n = $urandom_range(99);
         if (n < 30) repeat ($urandom_range(40, 150)) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
         rsp_stall <= 1'b1;
         n = $urandom_range(99);
         if (n < 90) repeat ($urandom_range(1, 4)) @(posedge clock);
         else repeat ($urandom_range(20, 80)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // sample side
   initial begin
      logic [RAW_BITS-1:0] corner_counts[$];
      int unsigned         sel;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero, just inside, at and beyond full scale, all ones
      corner_counts = '{16'd0, 16'd1, 16'd2, 16'd2048, 16'd4094, 16'd4095, 16'd4096,
                        16'd4097, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd1000};
      foreach (corner_counts[i]) send_sample(corner_counts[i], pick_gap());
      // a write to a missing register must change nothing
      write_reg(CSR_SPARE, 20'hFFFFF);
      send_sample(16'd2048, 0);

      // widest full scale, huge series, tiny nominal: deep saturation
      write_all(65536, 1048575, 1, 2000, 16383);
      send_sample(16'd1, 0);
      send_sample(16'hFFFF, 0);
      send_sample(16'h8000, pick_gap());
      // negative divisor: tiny ratio with a small beta
      write_all(65536, 1, 1048575, -2000, 1);
      send_sample(16'd1, 0);
      send_sample(16'd3, 0);
      send_sample(16'hFFFF, pick_gap());
      // zero registers make every count invalid
      write_all(0, 0, 0, -2048, 0);
      send_sample(16'd0, 0);
      send_sample(16'd100, 0);
      write_all(4096, 10000, 10000, 2047, 0);
      send_sample(16'd2048, 0);

      // random settings, extremes mixed in, one phase of stock values first
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0) begin
            write_all(FULL_RESET, SERIES_RESET, NOMINAL_RESET, NOM_TEMP_RESET, BETA_RESET);
         end else begin
            sel = $urandom_range(3);
            write_all(sel == 0 ? 65536 : sel == 1 ? 1024 : $urandom_range(2, 65536),
                      ($urandom_range(9) == 0) ? $urandom_range(1) * 1048575
                                               : $urandom_range(1, 1048575),
                      ($urandom_range(9) == 0) ? 1 : $urandom_range(100, 1048575),
                      int'($urandom_range(4000)) - 2000,
                      ($urandom_range(9) == 0) ? 16383 : $urandom_range(1, 16383));
         end
         // the long hold lands on a full phase of words, so the pipe fills up
         if (ph == 0) hold_go = 1'b1;
         for (int i = 0; i < PHASE_WORDS; i++) send_sample(pick_raw(), pick_gap());
      end
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("** ntc_beta_temperature_unit: PASSED **");
      else $display("** ntc_beta_temperature_unit: FAILED **");
      $finish;
   end

   // guard against a hang
   initial begin
      #5_000_000;
      $display("** ntc_beta_temperature_unit: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ntcbt_pkg.sv
hw/rtl/ntcbt_log_cell.sv
hw/rtl/ntcbt_div_cell.sv
hw/rtl/ntc_beta_temperature_unit.sv
tb/ntcbt_checker.sv
tb/tb_ntc_beta_temperature_unit.sv
